/* rtl/scba_pkg.sv */
package scba_pkg;

  localparam int unsigned ARENA_BYTES  = 65536;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned START_OFFSET = 24;
  localparam int unsigned NUM_CLASSES  = 14;
  localparam int unsigned MAX_REQUEST  = 640;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned CLASS_W    = 4;
  localparam int unsigned CARVE_W    = 17;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SIZE_W     = 10;

  // Offsets are 16 bits, so nothing is carved past 64 KiB whatever the arena.
  localparam int unsigned ARENA_CEIL = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
  localparam logic [CARVE_W-1:0] ARENA_LIMIT = CARVE_W'(ARENA_CEIL);
  localparam logic [CARVE_W-1:0] CAPACITY_RESET = CARVE_W'(65536);
  localparam logic [CARVE_W-1:0] CARVE_RESET = CARVE_W'(START_OFFSET);

  // Lowest legal user offset, and the low nibble every legal user offset has.
  localparam logic [OFF_W-1:0] FREE_LOW   = OFF_W'(HEADER_BYTES + START_OFFSET);
  localparam logic [3:0]       FREE_PHASE = 4'((HEADER_BYTES + START_OFFSET) % 16);
  localparam logic [3:0]       START_PHASE = 4'(START_OFFSET % 16);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  user_offset;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]   block_offset;
    logic [CLASS_W-1:0] size_class;
    logic [1:0]         status;
  } out_t;

  // Decoded request, carried from the accept cycle into the update cycle.
  typedef struct packed {
    logic               op;
    logic [CLASS_W-1:0] cls;
    logic               size_ok;
    logic               free_ok;
    logic [SLOT_W-1:0]  free_slot;
  } dec_t;

  function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    logic [SIZE_W-1:0] b;
    case (c)
      4'd0:    b = 10'd16;
      4'd1:    b = 10'd32;
      4'd2:    b = 10'd64;
      4'd3:    b = 10'd96;
      4'd4:    b = 10'd128;
      4'd5:    b = 10'd160;
      4'd6:    b = 10'd192;
      4'd7:    b = 10'd224;
      4'd8:    b = 10'd256;
      4'd9:    b = 10'd320;
      4'd10:   b = 10'd384;
      4'd11:   b = 10'd448;
      4'd12:   b = 10'd512;
      4'd13:   b = 10'd640;
      default: b = 10'd0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/scba_ram.sv */
module scba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scba_decode.sv */
module scba_decode (
  input  scba_pkg::in_t                      req_i,
  input  logic [scba_pkg::CARVE_W-1:0]       carve_i,
  output scba_pkg::dec_t                     dec_o
);
  import scba_pkg::*;

  logic [CLASS_W-1:0] cls;
  logic [OFF_W-1:0]   pos;

  // The class is the count of class sizes below the request, over all but the last.
  always_comb begin
    cls = '0;
    for (int k = 0; k < NUM_CLASSES - 1; k++) begin
      if (req_i.request_size > class_bytes(CLASS_W'(k))) begin
        cls = cls + CLASS_W'(1);
      end
    end
  end

  assign pos = req_i.user_offset - OFF_W'(HEADER_BYTES);

  always_comb begin
    dec_o.op        = req_i.op;
    dec_o.cls       = cls;
    dec_o.size_ok   = (req_i.request_size != '0) &&
                      (req_i.request_size <= SIZE_W'(MAX_REQUEST));
    dec_o.free_ok   = (req_i.user_offset >= FREE_LOW) &&
                      ({1'b0, req_i.user_offset} < carve_i) &&
                      (req_i.user_offset[3:0] == FREE_PHASE);
    dec_o.free_slot = pos[4 +: SLOT_W];
  end

endmodule

/* rtl/size_class_block_allocator_unit.sv */
// Size-class block allocator over a 64 KiB arena, all positions as byte offsets.
// Requests enter on req_i and are taken at a clock edge with start high and busy
// low. An allocate maps request_size to one of 14 classes and either reuses the
// oldest freed block of that class or carves a new one from the carve pointer;
// a free checks user_offset and appends the block to its class queue.
// Every request gives exactly one result on res_o, marked by res_valid_o for a
// single cycle. The receiver cannot stall; the result must be taken then.
// The result is registered: the accepting edge moves the block into the update
// state, and the edge that ends the update state raises the result strobe.
// A new request is not taken until the last one is through. The accepting cycle
// reads the link and class memories, the update cycle modifies the queue and
// writes the memories back, and busy stays high through the update cycle.
// The capacity register is written on its own valid/ready channel, always ready;
// write it only while no transaction is in flight.
// Reset empties every class queue, sets the carve pointer to the start offset
// and capacity to 65536. The link and class memories are not cleared: only
// entries written earlier are ever read for legal traffic.
module size_class_block_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  scba_pkg::in_t                  req_i,
  output logic                           res_valid_o,
  output scba_pkg::out_t                 res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [scba_pkg::CARVE_W-1:0]   cfg_data_i
);
  import scba_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  dec_t   dec_d, dec_q;
  out_t   res_d, res_q;
  logic   res_valid_q;
  logic   accept;
  logic   exec;

  logic [CARVE_W-1:0] capacity_q;
  logic [CARVE_W-1:0] carve_q;
  logic [CARVE_W-1:0] limit;

  // Per-class FIFO bookkeeping: head, tail and a nonempty flag per class.
  logic [SLOT_W-1:0]      head_q [NUM_CLASSES];
  logic [SLOT_W-1:0]      tail_q [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] qne_q;

  // Memory ports.
  logic               nl_we;
  logic [SLOT_W-1:0]  nl_waddr, nl_wdata, nl_raddr, nl_rdata;
  logic               bc_we;
  logic [SLOT_W-1:0]  bc_waddr, bc_raddr;
  logic [CLASS_W-1:0] bc_wdata, bc_rdata;

  // Update-cycle signals.
  logic               is_free;
  logic [CLASS_W-1:0] a_cls;
  logic               reuse;
  logic [CARVE_W:0]   need;
  logic               oom;
  logic [SLOT_W-1:0]  a_slot;
  logic [OFF_W-1:0]   a_pos;
  logic [CLASS_W-1:0] f_cls;
  logic [SLOT_W-1:0]  f_slot;
  logic               alloc_ok;
  logic               free_go;

  assign accept      = start && !busy;
  assign exec        = (state_q == S_EXEC);
  assign busy        = exec;
  assign cfg_ready_o = 1'b1;

  scba_decode u_decode (
    .req_i   (req_i),
    .carve_i (carve_q),
    .dec_o   (dec_d)
  );

  // Reads are issued with the accepting edge; data is valid in the update cycle.
  assign nl_raddr = head_q[dec_d.cls];
  assign bc_raddr = dec_d.free_slot;

  scba_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  scba_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (SLOT_COUNT)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (bc_we),
    .waddr_i (bc_waddr),
    .wdata_i (bc_wdata),
    .raddr_i (bc_raddr),
    .rdata_o (bc_rdata)
  );

  // The carve limit is the smaller of the capacity register and the arena.
  assign limit = (capacity_q < ARENA_LIMIT) ? capacity_q : ARENA_LIMIT;

  // Allocation path. A queued block of the class wins over carving.
  assign is_free = (op_e'(dec_q.op) == OP_FREE);
  assign a_cls   = dec_q.cls;
  assign reuse   = qne_q[a_cls];
  assign need    = {1'b0, carve_q} + (CARVE_W + 1)'(HEADER_BYTES) +
                   (CARVE_W + 1)'(class_bytes(a_cls));
  assign oom     = need > {1'b0, limit};
  assign a_slot  = reuse ? head_q[a_cls] : carve_q[4 +: SLOT_W];
  assign a_pos   = reuse ? {head_q[a_cls], START_PHASE} : carve_q[OFF_W-1:0];
  assign alloc_ok = exec && !is_free && dec_q.size_ok && (reuse || !oom);

  // Free path. A class code out of range is treated as the smallest class.
  assign f_cls   = (bc_rdata < CLASS_W'(NUM_CLASSES)) ? bc_rdata : '0;
  assign f_slot  = dec_q.free_slot;
  assign free_go = exec && is_free && dec_q.free_ok;

  assign bc_we    = alloc_ok;
  assign bc_waddr = a_slot;
  assign bc_wdata = a_cls;

  // Appending to a nonempty queue links the old tail to the new block.
  assign nl_we    = free_go && qne_q[f_cls];
  assign nl_waddr = tail_q[f_cls];
  assign nl_wdata = f_slot;

  always_comb begin
    res_d = '0;
    res_d.status = ST_OK;
    if (!is_free) begin
      if (!dec_q.size_ok) begin
        res_d.status = ST_BAD;
      end else if (!reuse && oom) begin
        res_d.status = ST_OOM;
      end else begin
        res_d.block_offset = a_pos + OFF_W'(HEADER_BYTES);
        res_d.size_class   = a_cls;
      end
    end else begin
      if (!dec_q.free_ok) begin
        res_d.status = ST_BAD;
      end else begin
        res_d.size_class = f_cls;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      dec_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            dec_q   <= dec_d;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q       <= res_d;
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carve_q <= CARVE_RESET;
      qne_q   <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
      end
    end else begin
      if (alloc_ok) begin
        if (reuse) begin
          // Pop the oldest block; the link read at accept gives the next head.
          if (head_q[a_cls] == tail_q[a_cls]) begin
            qne_q[a_cls] <= 1'b0;
          end else begin
            head_q[a_cls] <= nl_rdata;
          end
        end else begin
          carve_q <= need[CARVE_W-1:0];
        end
      end
      if (free_go) begin
        if (qne_q[f_cls]) begin
          tail_q[f_cls] <= f_slot;
        end else begin
          head_q[f_cls] <= f_slot;
          tail_q[f_cls] <= f_slot;
          qne_q[f_cls]  <= 1'b1;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // An accepted transaction always enters the update state.
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter the update cycle");

  a_exec_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && res_valid_o))
    else $error("update cycle did not end in a single result strobe");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |->
      ((res_o.block_offset == '0) && (res_o.size_class == '0)))
    else $error("error result carries a nonzero offset or class");

  a_carve_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve_q <= ARENA_LIMIT)
    else $error("carve pointer ran past the arena");

  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nl_we || bc_we) |-> busy)
    else $error("memory written outside the update cycle");

endmodule

/* tb/size_class_block_allocator_unit_tb.sv */
// Self-checking bench for the size-class block allocator.
//
// A short directed table covers bad sizes, bad frees, several class boundaries,
// block reuse and a double free. A long random run follows, split into phases
// that each start with a capacity write: the largest arena, the smallest one
// (every carve runs out of memory), values just over the carve pointer, random ones.
// Every accepted request transaction is fed to a predictor that keeps its own
// copy of the carve pointer, the per-class free FIFOs and the link and class
// memories. Every result strobe is checked against the oldest prediction.
module size_class_block_allocator_unit_tb;
  import scba_pkg::*;

  // Quiet cycles, with no transaction of any kind, before the run is abandoned.
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  // The result strobe follows the update state; allow margin.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DIRECTED_ROWS   = 25;
  localparam int unsigned PHASE_COUNT     = 5;
  localparam int unsigned IDLE_PERCENT    = 37;

  // One row of the directed table. When typed is set, want is the result read
  // straight off the specification; otherwise the predictor supplies it.
  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  uoff;
    logic              typed;
    out_t              want;
  } vector_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  in_t                req_i;
  logic               res_valid_o;
  out_t               res_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CARVE_W-1:0] cfg_data_i;

  size_class_block_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the allocator. Memories are two-state so that they start
  // at zero; the stimulus never reads an entry that was not written first.
  logic [CARVE_W-1:0] cap_reg   = CAPACITY_RESET;
  logic [CARVE_W-1:0] carve_ptr = CARVE_RESET;
  bit   [SLOT_W-1:0]  fifo_head [NUM_CLASSES];
  bit   [SLOT_W-1:0]  fifo_tail [NUM_CLASSES];
  bit                 fifo_live [NUM_CLASSES];
  bit   [SLOT_W-1:0]  link_mem  [SLOT_COUNT];
  bit   [CLASS_W-1:0] class_mem [SLOT_COUNT];
  // Slots that start a carved block: only these may pass the free checks.
  bit                 carved    [SLOT_COUNT];

  out_t               pending_results [$];
  // User offsets handed out and not yet picked for a free, and every offset ever carved.
  logic [OFF_W-1:0]   live_blocks     [$];
  logic [OFF_W-1:0]   carved_offsets  [$];

  int unsigned        error_count  = 0;
  int unsigned        quiet_cycles = 0;
  out_t               oldest;

  // Bytes of user memory behind each class: 16, 32, then steps of 32 up to
  // 256, steps of 64 up to 512, and finally 640.
  function automatic int unsigned block_span(input int unsigned c);
    if (c < 2) begin
      return 16 << c;
    end else if (c <= 8) begin
      return 32 * c;
    end else if (c <= 12) begin
      return 64 * (c - 4);
    end
    return 640;
  endfunction

  // Smallest class that holds the request.
  function automatic logic [CLASS_W-1:0] class_for(input logic [SIZE_W-1:0] sz);
    int unsigned c;
    c = 0;
    while (c + 1 < NUM_CLASSES && sz > block_span(c)) c++;
    return CLASS_W'(c);
  endfunction

  // Applies one accepted request to the shadow state and returns its result.
  function automatic out_t allocator_outcome(input in_t rq);
    out_t               r;
    logic [CLASS_W-1:0] c;
    logic [CARVE_W-1:0] pos;
    logic [CARVE_W-1:0] need;
    logic [CARVE_W-1:0] lim;
    logic [SLOT_W-1:0]  slot;
    r = '0;
    if (rq.op == OP_ALLOC) begin
      if (rq.request_size == 0 || rq.request_size > MAX_REQUEST) begin
        r.status = ST_BAD;
        return r;
      end
      c = class_for(rq.request_size);
      if (fifo_live[c]) begin
        // Reuse the oldest freed block of this class.
        slot = fifo_head[c];
        if (fifo_head[c] == fifo_tail[c]) begin
          fifo_live[c] = 1'b0;
        end else begin
          fifo_head[c] = link_mem[slot];
        end
        pos = {1'b0, slot, 4'h0} + CARVE_W'(START_PHASE);
      end else begin
        need = carve_ptr + CARVE_W'(HEADER_BYTES) + CARVE_W'(block_span(c));
        lim  = (cap_reg < ARENA_LIMIT) ? cap_reg : ARENA_LIMIT;
        if (need > lim) begin
          r.status = ST_OOM;
          return r;
        end
        pos          = carve_ptr;
        carve_ptr    = need;
        slot         = pos[15:4];
        carved[slot] = 1'b1;
        carved_offsets.push_back(OFF_W'(pos + HEADER_BYTES));
      end
      class_mem[slot] = c;
      r.block_offset  = OFF_W'(pos + HEADER_BYTES);
      r.size_class    = c;
      r.status        = ST_OK;
      live_blocks.push_back(r.block_offset);
    end else begin
      // A legal user offset lies past the header, below the carve pointer and
      // on the 16-byte grid that every block start sits on.
      if (rq.user_offset < FREE_LOW || CARVE_W'(rq.user_offset) >= carve_ptr ||
          rq.user_offset[3:0] != FREE_PHASE) begin
        r.status = ST_BAD;
        return r;
      end
      slot = SLOT_W'((rq.user_offset - HEADER_BYTES) >> 4);
      c    = class_mem[slot];
      if (c >= NUM_CLASSES) c = '0;
      // Append without any duplicate check, exactly as a double free does.
      if (fifo_live[c]) begin
        link_mem[fifo_tail[c]] = slot;
        fifo_tail[c]           = slot;
      end else begin
        fifo_head[c] = slot;
        fifo_tail[c] = slot;
        fifo_live[c] = 1'b1;
      end
      r.size_class = c;
      r.status     = ST_OK;
    end
    return r;
  endfunction

  // Directed table. The first rows run straight after reset, so their results
  // are plain to see; the class boundary rows lean on the predictor.
  function automatic vector_t directed_row(input int unsigned idx);
    vector_t v;
    case (idx)
      // Sizes of zero and above the largest class are refused.
      0:  v = '{OP_ALLOC, 10'd0,    16'd0,      1'b1, '{16'd0,  4'd0, ST_BAD}};
      1:  v = '{OP_ALLOC, 10'd1023, 16'hFFFF,   1'b1, '{16'd0,  4'd0, ST_BAD}};
      2:  v = '{OP_ALLOC, 10'd641,  16'd0,      1'b1, '{16'd0,  4'd0, ST_BAD}};
      // Frees below the first block and past the carve pointer.
      3:  v = '{OP_FREE,  10'd0,    16'd0,      1'b1, '{16'd0,  4'd0, ST_BAD}};
      4:  v = '{OP_FREE,  10'h3FF,  16'hFFFF,   1'b1, '{16'd0,  4'd0, ST_BAD}};
      // First carve lands just past the header.
      5:  v = '{OP_ALLOC, 10'd1,    16'd0,      1'b1, '{16'd40, 4'd0, ST_OK}};
      // Off the block grid by one byte.
      6:  v = '{OP_FREE,  10'd0,    16'd41,     1'b1, '{16'd0,  4'd0, ST_BAD}};
      7:  v = '{OP_FREE,  10'd0,    16'd40,     1'b1, '{16'd0,  4'd0, ST_OK}};
      // The freed block comes straight back.
      8:  v = '{OP_ALLOC, 10'd16,   16'd0,      1'b1, '{16'd40, 4'd0, ST_OK}};
      9:  v = '{OP_ALLOC, 10'd640,  16'd0,      1'b0, '0};
      10: v = '{OP_ALLOC, 10'd17,   16'd0,      1'b0, '0};
      11: v = '{OP_ALLOC, 10'd32,   16'd0,      1'b0, '0};
      12: v = '{OP_ALLOC, 10'd33,   16'd0,      1'b0, '0};
      13: v = '{OP_ALLOC, 10'd64,   16'd0,      1'b0, '0};
      14: v = '{OP_ALLOC, 10'd65,   16'd0,      1'b0, '0};
      15: v = '{OP_ALLOC, 10'd97,   16'd0,      1'b0, '0};
      16: v = '{OP_ALLOC, 10'd160,  16'd0,      1'b0, '0};
      17: v = '{OP_ALLOC, 10'd224,  16'd0,      1'b0, '0};
      18: v = '{OP_ALLOC, 10'd256,  16'd0,      1'b0, '0};
      19: v = '{OP_ALLOC, 10'd448,  16'd0,      1'b0, '0};
      20: v = '{OP_ALLOC, 10'd513,  16'd0,      1'b0, '0};
      // The largest block, freed twice: it is then handed out once from the
      // queue and the next request carves afresh.
      21: v = '{OP_FREE,  10'd0,    16'd72,     1'b0, '0};
      22: v = '{OP_FREE,  10'd0,    16'd72,     1'b0, '0};
      23: v = '{OP_ALLOC, 10'd600,  16'd0,      1'b0, '0};
      default: v = '{OP_ALLOC, 10'd600, 16'd0,  1'b0, '0};
    endcase
    return v;
  endfunction

  // Random request. Most traffic is well formed: allocations, mostly small,
  // and frees of blocks that are live. A few double frees and raw noise fill
  // the rest. Noise never frees an offset that would pass the checks without
  // being a block start; such an offset is pushed off the grid instead.
  function automatic in_t pick_request();
    in_t         rq;
    int unsigned roll;
    int unsigned k;
    rq.op           = OP_ALLOC;
    rq.request_size = SIZE_W'($urandom_range(1, MAX_REQUEST));
    rq.user_offset  = OFF_W'($urandom_range(65535));
    if ($urandom_range(3) != 0) rq.request_size = SIZE_W'($urandom_range(1, 128));
    roll = $urandom_range(99);
    if (roll < 30 && live_blocks.size() != 0) begin
      k              = $urandom_range(live_blocks.size() - 1);
      rq.op          = OP_FREE;
      rq.user_offset = live_blocks[k];
      live_blocks.delete(k);
    end else if (roll >= 30 && roll < 34 && carved_offsets.size() != 0) begin
      rq.op          = OP_FREE;
      rq.user_offset = carved_offsets[$urandom_range(carved_offsets.size() - 1)];
    end else if (roll >= 34 && roll < 46) begin
      rq.op           = 1'($urandom_range(1));
      rq.request_size = SIZE_W'($urandom_range(1023));
      if (rq.op == OP_FREE && rq.user_offset >= FREE_LOW &&
          CARVE_W'(rq.user_offset) < carve_ptr && rq.user_offset[3:0] == FREE_PHASE &&
          !carved[SLOT_W'((rq.user_offset - HEADER_BYTES) >> 4)]) begin
        rq.user_offset[0] = ~rq.user_offset[0];
      end
    end
    return rq;
  endfunction

  // Offers one request transaction and waits for the edge that takes it. The
  // prediction is made at that edge, so it always sees the state left by the
  // previous transaction. start is left high for a back-to-back follower.
  task automatic offer_request(input in_t rq, input logic typed, input out_t want);
    out_t predicted;
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predicted = allocator_outcome(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // With idling enabled, drops start now and then.
  task automatic sender_gap(input bit allow);
    if (allow && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // The capacity register may only change with nothing in flight: drain all
  // outstanding results, let the pipeline settle, then do the write.
  task automatic write_capacity(input logic [CARVE_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_reg = value;
  endtask

  // Result checker. Outputs are sampled at the edge that ends the strobe
  // cycle, before the block's own updates for that edge take effect.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: offset %0d class %0d status %0d",
                 $time, res_o.block_offset, res_o.size_class, res_o.status);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (res_o.block_offset !== oldest.block_offset) begin
          $display("%0t: block_offset expected %0d actual %0d",
                   $time, oldest.block_offset, res_o.block_offset);
          error_count++;
        end
        if (res_o.size_class !== oldest.size_class) begin
          $display("%0t: size_class expected %0d actual %0d",
                   $time, oldest.size_class, res_o.size_class);
          error_count++;
        end
        if (res_o.status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest.status, res_o.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any request, result or configuration transaction counts as
  // progress. A long silence means a lost handshake or a stuck busy.
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || res_valid_o === 1'b1 ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    vector_t            row;
    logic [CARVE_W-1:0] cap;
    int unsigned        count;
    bit                 allow;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_capacity(CAPACITY_RESET);
    for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_row(i);
      offer_request('{row.op, row.size, row.uoff}, row.typed, row.want);
      sender_gap(1'b1);
    end

    // Each phase drains the block before its capacity write, so the sender
    // also pauses with every result delivered. The first phase runs with no
    // idling at all; the second shrinks the arena below the carve pointer so
    // that only queued blocks can be handed out.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      allow = 1'b1;
      case (p)
        0: begin
          cap   = CAPACITY_RESET;
          count = 150;
          allow = 1'b0;
        end
        1: begin
          cap   = CARVE_W'(25);
          count = 80;
        end
        2: begin
          cap   = carve_ptr + CARVE_W'($urandom_range(0, 600));
          if (cap > CAPACITY_RESET) cap = CAPACITY_RESET;
          count = 120;
        end
        3: begin
          cap   = CAPACITY_RESET;
          count = 150;
        end
        default: begin
          cap   = CARVE_W'($urandom_range(25, 65536));
          count = 150;
        end
      endcase
      write_capacity(cap);
      repeat (count) begin
        offer_request(pick_request(), 1'b0, '0);
        sender_gap(allow);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
